FILE: rtl/tagged_operand_stack_macros.svh
// Assertion macros shared by the tagged operand stack RTL.
`ifndef TAGGED_OPERAND_STACK_MACROS_SVH
`define TAGGED_OPERAND_STACK_MACROS_SVH

// Check a property at every clock edge outside reset.
`define TOS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TOS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tos_pkg.sv
// Shared types and constants of the tagged operand stack.
package tos_pkg;

  localparam int unsigned CMD_W    = 4;
  localparam int unsigned PICK_W   = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 4'd0,
    CMD_DUP      = 4'd1,
    CMD_DROP     = 4'd2,
    CMD_SWAP     = 4'd3,
    CMD_ROT      = 4'd4,
    CMD_OVER     = 4'd5,
    CMD_NIP      = 4'd6,
    CMD_TUCK     = 4'd7,
    CMD_TWODUP   = 4'd8,
    CMD_PICK     = 4'd9,
    CMD_POP      = 4'd10,
    CMD_TYPEDPOP = 4'd11
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_MISMATCH  = 2'd3
  } status_e;

  typedef struct packed {
    logic              fire;
    logic [PICK_W-1:0] next_pick;
  } tos_ctrl_t;

endpackage

FILE: rtl/tos_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module tos_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/tos_exec.sv
// Stack execution unit: top-of-stack window registers, spill RAM banks, command logic.
`include "tagged_operand_stack_macros.svh"

module tos_exec import tos_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned TAG_BITS     = 4,
  parameter int unsigned PAYLOAD_BITS = 32,
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tos_ctrl_t               ctrl_i,
  input  cmd_e                    cmd_i,
  input  logic [TAG_BITS-1:0]     push_tag_i,
  input  logic [PAYLOAD_BITS-1:0] push_payload_i,
  input  logic [PICK_W-1:0]       pick_index_i,
  input  logic [TAG_BITS-1:0]     expected_tag_i,
  output logic [TAG_BITS-1:0]     popped_tag_o,
  output logic [PAYLOAD_BITS-1:0] popped_payload_o,
  output logic [DEPTH_W-1:0]      depth_o,
  output status_e                 status_o
);

  localparam int unsigned TOK_W      = TAG_BITS + PAYLOAD_BITS;
  localparam int unsigned IW         = $clog2(STACK_DEPTH);
  localparam int unsigned BAW        = IW - 1;
  localparam int unsigned BANK_DEPTH = 1 << BAW;
  localparam int unsigned CW         = (DEPTH_W > PICK_W) ? DEPTH_W + 1 : PICK_W + 2;

  logic [TOK_W-1:0]   r0_q, r1_q, r2_q;
  logic [TOK_W-1:0]   r0_nx, r1_nx, r2_nx;
  logic [DEPTH_W-1:0] depth_q, depth_nx, depth_d;
  logic [CW-1:0]      depth_ext, need, grow;
  logic               wr0_en, wr1_en, wr0_go, wr1_go;
  logic [IW-1:0]      wi0, wi1, ridx_a, ridx_b;
  logic [TOK_W-1:0]   popped, below, pick_tok, push_tok;
  logic [TOK_W-1:0]   rd_a [2];
  logic [TOK_W-1:0]   rd_b [2];
  logic               sel_a_q, sel_b_q, hit_a_q, hit_b_q;
  logic               hit_a, hit_b;
  logic [TOK_W-1:0]   byp_a_q, byp_b_q, byp_a, byp_b;
  status_e            status;

  assign push_tok  = {push_tag_i, push_payload_i};
  assign depth_ext = CW'(depth_q);
  assign wi0       = IW'(depth_ext - CW'(3));
  assign wi1       = IW'(depth_ext - CW'(2));
  assign below     = hit_a_q ? byp_a_q : rd_a[sel_a_q];

  always_comb begin
    case (pick_index_i)
      PICK_W'(0): pick_tok = r0_q;
      PICK_W'(1): pick_tok = r1_q;
      PICK_W'(2): pick_tok = r2_q;
      default:    pick_tok = hit_b_q ? byp_b_q : rd_b[sel_b_q];
    endcase
  end

  always_comb begin
    need = '0;
    grow = '0;
    case (cmd_i)
      CMD_PUSH:     grow = CW'(1);
      CMD_DUP:      begin need = CW'(1); grow = CW'(1); end
      CMD_DROP:     need = CW'(1);
      CMD_SWAP:     need = CW'(2);
      CMD_ROT:      need = CW'(3);
      CMD_OVER:     begin need = CW'(2); grow = CW'(1); end
      CMD_NIP:      need = CW'(2);
      CMD_TUCK:     begin need = CW'(2); grow = CW'(1); end
      CMD_TWODUP:   begin need = CW'(2); grow = CW'(2); end
      CMD_PICK:     begin need = CW'(pick_index_i) + CW'(1); grow = CW'(1); end
      CMD_POP:      need = CW'(1);
      CMD_TYPEDPOP: need = CW'(1);
      default:      need = '0;
    endcase
  end

  always_comb begin
    r0_nx    = r0_q;
    r1_nx    = r1_q;
    r2_nx    = r2_q;
    depth_nx = depth_q;
    wr0_en   = 1'b0;
    wr1_en   = 1'b0;
    popped   = '0;
    status   = STATUS_OK;
    if (depth_ext < need) begin
      status = STATUS_UNDERFLOW;
    end else if (depth_ext + grow > CW'(STACK_DEPTH)) begin
      status = STATUS_OVERFLOW;
    end else begin
      case (cmd_i)
        CMD_PUSH, CMD_DUP, CMD_OVER, CMD_PICK: begin
          case (cmd_i)
            CMD_PUSH: r0_nx = push_tok;
            CMD_OVER: r0_nx = r1_q;
            CMD_PICK: r0_nx = pick_tok;
            default:  r0_nx = r0_q;
          endcase
          r1_nx    = r0_q;
          r2_nx    = r1_q;
          wr0_en   = depth_ext >= CW'(3);
          depth_nx = depth_q + DEPTH_W'(1);
        end
        CMD_DROP, CMD_POP, CMD_TYPEDPOP: begin
          r0_nx    = r1_q;
          r1_nx    = r2_q;
          r2_nx    = below;
          depth_nx = depth_q - DEPTH_W'(1);
          if (cmd_i != CMD_DROP) begin
            popped = r0_q;
          end
          if (cmd_i == CMD_TYPEDPOP && r0_q[TOK_W-1:PAYLOAD_BITS] != expected_tag_i) begin
            status = STATUS_MISMATCH;
          end
        end
        CMD_SWAP: begin
          r0_nx = r1_q;
          r1_nx = r0_q;
        end
        CMD_ROT: begin
          r0_nx = r2_q;
          r1_nx = r0_q;
          r2_nx = r1_q;
        end
        CMD_NIP: begin
          r1_nx    = r2_q;
          r2_nx    = below;
          depth_nx = depth_q - DEPTH_W'(1);
        end
        CMD_TUCK: begin
          r2_nx    = r0_q;
          wr0_en   = depth_ext >= CW'(3);
          depth_nx = depth_q + DEPTH_W'(1);
        end
        CMD_TWODUP: begin
          r2_nx    = r0_q;
          wr0_en   = depth_ext >= CW'(3);
          wr1_en   = 1'b1;
          depth_nx = depth_q + DEPTH_W'(2);
        end
        default: depth_nx = depth_q;
      endcase
    end
  end

  assign wr0_go  = ctrl_i.fire && wr0_en;
  assign wr1_go  = ctrl_i.fire && wr1_en;
  assign depth_d = ctrl_i.fire ? depth_nx : depth_q;
  assign ridx_a  = IW'(CW'(depth_d) - CW'(4));
  assign ridx_b  = IW'(CW'(depth_d) - CW'(ctrl_i.next_pick) - CW'(1));

  assign hit_a = (wr0_go && wi0 == ridx_a) || (wr1_go && wi1 == ridx_a);
  assign hit_b = (wr0_go && wi0 == ridx_b) || (wr1_go && wi1 == ridx_b);
  assign byp_a = (wr1_go && wi1 == ridx_a) ? r1_q : r2_q;
  assign byp_b = (wr1_go && wi1 == ridx_b) ? r1_q : r2_q;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic             we;
    logic [BAW-1:0]   wa;
    logic [TOK_W-1:0] wd;

    always_comb begin
      we = 1'b0;
      wa = wi0[IW-1:1];
      wd = r2_q;
      if (wr0_go && wi0[0] == 1'(b)) begin
        we = 1'b1;
      end else if (wr1_go && wi1[0] == 1'(b)) begin
        we = 1'b1;
        wa = wi1[IW-1:1];
        wd = r1_q;
      end
    end

    tos_ram #(
      .WIDTH(TOK_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (wa),
      .wdata_i   (wd),
      .raddr_a_i (ridx_a[IW-1:1]),
      .raddr_b_i (ridx_b[IW-1:1]),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      hit_a_q <= hit_a;
      hit_b_q <= hit_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      r0_q <= r0_nx;
      r1_q <= r1_nx;
      r2_q <= r2_nx;
    end
    sel_a_q <= ridx_a[0];
    sel_b_q <= ridx_b[0];
    byp_a_q <= byp_a;
    byp_b_q <= byp_b;
  end

  assign popped_tag_o     = popped[TOK_W-1:PAYLOAD_BITS];
  assign popped_payload_o = popped[PAYLOAD_BITS-1:0];
  assign depth_o          = depth_nx;
  assign status_o         = status;

  `TOS_ASSERT(a_depth_bound, depth_q <= DEPTH_W'(STACK_DEPTH), "depth beyond capacity")
  `TOS_ASSERT(a_bank_split, !(wr0_go && wr1_go) || (wi0[0] != wi1[0]), "two spills in one bank")
  `TOS_ASSERT_NEXT(a_fault_hold, ctrl_i.fire && (status == STATUS_UNDERFLOW || status == STATUS_OVERFLOW), $stable(depth_q), "faulted command moved depth")
  `TOS_ASSERT_NEXT(a_pop_shrink, ctrl_i.fire && status == STATUS_OK && cmd_i == CMD_POP, depth_q == $past(depth_q) - DEPTH_W'(1), "pop did not shrink depth")

endmodule

FILE: rtl/tagged_operand_stack.sv
// Commands are registered on acceptance and results when they fire. Throughput: one
// command per cycle while the output is not stalled; deeper tokens come from two RAM
// banks whose registered reads are issued ahead from the next depth and pick index.
// Reset clears depth and the valid flags; stored tokens are not cleared.
// Top level of the tagged operand stack.
module tagged_operand_stack import tos_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned TAG_BITS     = 4,
  parameter int unsigned PAYLOAD_BITS = 32,
  localparam int unsigned DEPTH_W  = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IN_W     = CMD_W + TAG_BITS + PAYLOAD_BITS + PICK_W + TAG_BITS,
  localparam int unsigned IN_DW    = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W    = TAG_BITS + PAYLOAD_BITS + DEPTH_W + 1 + STATUS_W,
  localparam int unsigned OUT_DW   = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // command, push_tag, push_payload, pick_index, expected_tag
  input  logic [IN_DW-1:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // popped_tag, popped_payload, stack_depth, is_empty, status
  output logic [OUT_DW-1:0] m_axis_tdata_o
);

  localparam int unsigned O_TAG  = CMD_W;
  localparam int unsigned O_PAY  = O_TAG + TAG_BITS;
  localparam int unsigned O_PICK = O_PAY + PAYLOAD_BITS;
  localparam int unsigned O_EXP  = O_PICK + PICK_W;

  logic                    in_valid_q, out_valid_q, load, fire;
  cmd_e                    cmd_q;
  logic [TAG_BITS-1:0]     push_tag_q, expected_tag_q;
  logic [PAYLOAD_BITS-1:0] push_payload_q;
  logic [PICK_W-1:0]       pick_index_q, in_pick;
  tos_ctrl_t               ctrl;

  logic [TAG_BITS-1:0]     ex_tag, popped_tag_q;
  logic [PAYLOAD_BITS-1:0] ex_payload, popped_payload_q;
  logic [DEPTH_W-1:0]      ex_depth, depth_q;
  status_e                 ex_status, status_q;
  logic                    is_empty_q;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;
  assign in_pick         = s_axis_tdata_i[O_PICK +: PICK_W];

  assign ctrl.fire      = fire;
  assign ctrl.next_pick = load ? in_pick : pick_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q          <= cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
      push_tag_q     <= s_axis_tdata_i[O_TAG +: TAG_BITS];
      push_payload_q <= s_axis_tdata_i[O_PAY +: PAYLOAD_BITS];
      pick_index_q   <= in_pick;
      expected_tag_q <= s_axis_tdata_i[O_EXP +: TAG_BITS];
    end
    if (fire) begin
      popped_tag_q     <= ex_tag;
      popped_payload_q <= ex_payload;
      depth_q          <= ex_depth;
      is_empty_q       <= ex_depth == '0;
      status_q         <= ex_status;
    end
  end

  tos_exec #(
    .STACK_DEPTH  (STACK_DEPTH),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_exec (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .cmd_i            (cmd_q),
    .push_tag_i       (push_tag_q),
    .push_payload_i   (push_payload_q),
    .pick_index_i     (pick_index_q),
    .expected_tag_i   (expected_tag_q),
    .popped_tag_o     (ex_tag),
    .popped_payload_o (ex_payload),
    .depth_o          (ex_depth),
    .status_o         (ex_status)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DW'({status_q, is_empty_q, depth_q,
                                    popped_payload_q, popped_tag_q});

endmodule

FILE: test/tagged_operand_stack_tb.sv
// Self-checking testbench for the tagged operand stack: directed table, then random commands.
module tagged_operand_stack_tb import tos_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_CAP    = 64;
  localparam int unsigned RANDOM_ITEMS = 1925;
  localparam int unsigned QUIET_ITEMS  = 200;
  localparam int unsigned TABLE_ROWS   = 25;

  localparam logic [CMD_W-1:0] CMD_FIRST_UNDEF = 4'd12;
  localparam logic [CMD_W-1:0] CMD_LAST_UNDEF  = 4'd15;

  typedef struct packed {
    logic [3:0]        tag;
    logic [31:0]       payload;
  } token_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [3:0]        push_tag;
    logic [31:0]       push_payload;
    logic [PICK_W-1:0] pick_index;
    logic [3:0]        expected_tag;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]        popped_tag;
    logic [31:0]       popped_payload;
    logic [6:0]        stack_depth;
    logic              is_empty;
    status_e           status;
  } stack_result_t;

  typedef struct packed {
    cmd_item_t         item;
    logic              checked;
    stack_result_t     want;
  } table_row_t;

  typedef enum int {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIX} drift_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // command, push_tag, push_payload, pick_index, expected_tag
  logic [55:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // popped_tag, popped_payload, stack_depth, is_empty, status
  logic [47:0] m_axis_tdata_o;

  token_t        stack_mem [STACK_CAP];
  int unsigned   stack_fill = 0;
  stack_result_t pending_results [$];
  int unsigned   mismatch_count = 0;
  bit            bursts_on = 1'b1;

  cmd_e grow_cmds [6]   = '{CMD_PUSH, CMD_DUP, CMD_OVER, CMD_TUCK, CMD_TWODUP, CMD_PICK};
  cmd_e shrink_cmds [4] = '{CMD_DROP, CMD_NIP, CMD_POP, CMD_TYPEDPOP};

  table_row_t command_table [TABLE_ROWS] = '{
    '{'{CMD_POP,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd0, 1'b1, STATUS_UNDERFLOW}},
    '{'{CMD_TYPEDPOP,    4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd0, 1'b1, STATUS_UNDERFLOW}},
    '{'{CMD_PICK,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd0, 1'b1, STATUS_UNDERFLOW}},
    '{'{CMD_DUP,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd0, 1'b1, STATUS_UNDERFLOW}},
    '{'{CMD_LAST_UNDEF,  4'hF, 32'hFFFFFFFF, 6'd63, 4'hF}, 1'b1,
      '{4'h0, 32'h0, 7'd0, 1'b1, STATUS_OK}},
    '{'{CMD_PUSH,        4'hF, 32'hFFFFFFFF, 6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd1, 1'b0, STATUS_OK}},
    '{'{CMD_PUSH,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd2, 1'b0, STATUS_OK}},
    '{'{CMD_PUSH,        4'hA, 32'h5A5A5A5A, 6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd3, 1'b0, STATUS_OK}},
    '{'{CMD_PUSH,        4'h5, 32'hA5A5A5A5, 6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd4, 1'b0, STATUS_OK}},
    '{'{CMD_SWAP,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_ROT,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_OVER,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_NIP,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_TUCK,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_TWODUP,      4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_PICK,        4'h0, 32'h0,        6'd2,  4'h0}, 1'b0, '0},
    '{'{CMD_PICK,        4'h0, 32'h0,        6'd63, 4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd8, 1'b0, STATUS_UNDERFLOW}},
    '{'{CMD_DROP,        4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_TYPEDPOP,    4'h0, 32'h0,        6'd0,  4'hF}, 1'b0, '0},
    '{'{CMD_TYPEDPOP,    4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_POP,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_FIRST_UNDEF, 4'h0, 32'h0,        6'd0,  4'h0}, 1'b0, '0},
    '{'{CMD_PUSH,        4'hF, 32'hFFFFFFFF, 6'd0,  4'h0}, 1'b1,
      '{4'h0, 32'h0, 7'd5, 1'b0, STATUS_OK}},
    '{'{CMD_POP,         4'h0, 32'h0,        6'd0,  4'h0}, 1'b1,
      '{4'hF, 32'hFFFFFFFF, 7'd4, 1'b0, STATUS_OK}},
    '{'{CMD_TYPEDPOP,    4'h0, 32'h0,        6'd0,  4'hF}, 1'b0, '0}
  };

  tagged_operand_stack u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic stack_result_t stack_apply(input cmd_item_t it);
    stack_result_t res;
    token_t        a;
    token_t        b;
    token_t        c;
    int unsigned   need;
    int unsigned   grow;
    int unsigned   d;
    res  = '0;
    need = 0;
    grow = 0;
    d    = stack_fill;
    case (it.command)
      CMD_PUSH:     begin need = 0; grow = 1; end
      CMD_DUP:      begin need = 1; grow = 1; end
      CMD_DROP:     begin need = 1; grow = 0; end
      CMD_SWAP:     begin need = 2; grow = 0; end
      CMD_ROT:      begin need = 3; grow = 0; end
      CMD_OVER:     begin need = 2; grow = 1; end
      CMD_NIP:      begin need = 2; grow = 0; end
      CMD_TUCK:     begin need = 2; grow = 1; end
      CMD_TWODUP:   begin need = 2; grow = 2; end
      CMD_PICK:     begin need = it.pick_index + 1; grow = 1; end
      CMD_POP:      begin need = 1; grow = 0; end
      CMD_TYPEDPOP: begin need = 1; grow = 0; end
      default:      begin need = 0; grow = 0; end
    endcase
    res.status = STATUS_OK;
    if (d < need) begin
      res.status = STATUS_UNDERFLOW;
    end else if (d + grow > STACK_CAP) begin
      res.status = STATUS_OVERFLOW;
    end else begin
      case (it.command)
        CMD_PUSH: begin
          stack_mem[d] = '{it.push_tag, it.push_payload};
          d++;
        end
        CMD_DUP: begin
          stack_mem[d] = stack_mem[d-1];
          d++;
        end
        CMD_DROP: d--;
        CMD_SWAP: begin
          a = stack_mem[d-2];
          b = stack_mem[d-1];
          stack_mem[d-2] = b;
          stack_mem[d-1] = a;
        end
        CMD_ROT: begin
          a = stack_mem[d-3];
          b = stack_mem[d-2];
          c = stack_mem[d-1];
          stack_mem[d-3] = b;
          stack_mem[d-2] = c;
          stack_mem[d-1] = a;
        end
        CMD_OVER: begin
          stack_mem[d] = stack_mem[d-2];
          d++;
        end
        CMD_NIP: begin
          b = stack_mem[d-1];
          d--;
          stack_mem[d-1] = b;
        end
        CMD_TUCK: begin
          a = stack_mem[d-2];
          b = stack_mem[d-1];
          stack_mem[d-2] = b;
          stack_mem[d-1] = a;
          stack_mem[d]   = b;
          d++;
        end
        CMD_TWODUP: begin
          a = stack_mem[d-2];
          b = stack_mem[d-1];
          stack_mem[d]   = a;
          stack_mem[d+1] = b;
          d += 2;
        end
        CMD_PICK: begin
          stack_mem[d] = stack_mem[d-1-it.pick_index];
          d++;
        end
        CMD_POP, CMD_TYPEDPOP: begin
          a = stack_mem[d-1];
          d--;
          res.popped_tag     = a.tag;
          res.popped_payload = a.payload;
          if (it.command == CMD_TYPEDPOP && a.tag != it.expected_tag) begin
            res.status = STATUS_MISMATCH;
          end
        end
        default: ;
      endcase
    end
    stack_fill      = d;
    res.stack_depth = d[6:0];
    res.is_empty    = (d == 0);
    return res;
  endfunction

  function automatic cmd_item_t random_command(input drift_e mode);
    cmd_item_t   it;
    int unsigned r;
    int unsigned grow_pct;
    int unsigned shrink_pct;
    grow_pct   = (mode == DRIFT_GROW) ? 70 : (mode == DRIFT_SHRINK) ? 15 : 35;
    shrink_pct = (mode == DRIFT_SHRINK) ? 70 : (mode == DRIFT_GROW) ? 15 : 35;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.command = CMD_W'($urandom_range(CMD_FIRST_UNDEF, CMD_LAST_UNDEF));
    end else if (r < 4 + grow_pct) begin
      it.command = grow_cmds[$urandom_range(0, 5)];
    end else if (r < 4 + grow_pct + shrink_pct) begin
      it.command = shrink_cmds[$urandom_range(0, 3)];
    end else begin
      it.command = CMD_W'($urandom_range(CMD_PUSH, CMD_TYPEDPOP));
    end
    it.push_tag     = 4'($urandom_range(0, 15));
    it.push_payload = $urandom;
    if (stack_fill > 0 && $urandom_range(0, 3) != 0) begin
      it.pick_index = PICK_W'($urandom_range(0, stack_fill - 1));
    end else begin
      it.pick_index = PICK_W'($urandom_range(0, 63));
    end
    if (stack_fill > 0 && $urandom_range(0, 1) != 0) begin
      it.expected_tag = stack_mem[stack_fill-1].tag;
    end else begin
      it.expected_tag = 4'($urandom_range(0, 15));
    end
    return it;
  endfunction

  task automatic send_command(input cmd_item_t it, input logic checked,
                              input stack_result_t want);
    stack_result_t predicted;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, it.expected_tag, it.pick_index, it.push_payload,
                        it.push_tag, it.command};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = stack_apply(it);
    pending_results.push_back(checked ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("popped_tag", 32'(want.popped_tag), 32'(m_axis_tdata_o[3:0]));
        check_field("popped_payload", want.popped_payload, m_axis_tdata_o[35:4]);
        check_field("stack_depth", 32'(want.stack_depth), 32'(m_axis_tdata_o[42:36]));
        check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata_o[43]));
        check_field("status", 32'(want.status), 32'(m_axis_tdata_o[45:44]));
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    drift_e      mode;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < TABLE_ROWS; i++) begin
      send_command(command_table[i].item, command_table[i].checked, command_table[i].want);
    end
    while (sent < RANDOM_ITEMS) begin
      seg_len   = $urandom_range(20, 120);
      mode      = drift_e'($urandom_range(0, 2));
      bursts_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) bursts_on = 1'b0;
        send_command(random_command(mode), 1'b0, '0);
        sent++;
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tos_pkg.sv
rtl/tos_ram.sv
rtl/tos_exec.sv
rtl/tagged_operand_stack.sv
test/tagged_operand_stack_tb.sv
